/* hdl/pebt_pkg.sv */
// pebt_pkg: widths, constants, register indexes and stage types of the
// bilinear tap generator; no dependencies
package pebt_pkg;

   localparam int INDEX_W      = 24;
   localparam int GRID_W       = 11;
   localparam int SIDE_W       = 9;
   localparam int MERGE_W      = 4;
   localparam int TAP_W        = 16;
   localparam int WEIGHT_W     = 17;
   localparam int FRAC_BITS    = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 9;

   localparam int MAX_GRID_DIM   = 1024;
   localparam int MAX_TABLE_SIDE = 256;

   localparam int HW_W        = 21;
   localparam int MW_W        = 14;
   localparam int MM_W        = 8;
   localparam int POS_W       = 11;
   localparam int INNER_POS_W = 4;
   localparam int DEN_W       = 10;
   localparam int STEP_W      = 8;
   localparam int NUM_W       = POS_W + STEP_W;
   localparam int DIVIDEND_W  = NUM_W + FRAC_BITS;
   localparam int PROD_W      = 2 * WEIGHT_W;

   localparam int RSP_LATENCY = 120;

   localparam logic [SIDE_W-1:0]   TABLE_SIDE_RESET = SIDE_W'(48);
   localparam logic [MERGE_W-1:0]  MERGE_DIM_RESET  = MERGE_W'(2);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE       = WEIGHT_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]   PROD_HALF        = PROD_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TABLE_SIDE = 2'd0,
      CSR_MERGE_DIM  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] patch;
      logic [GRID_W-1:0]  grid_h;
      logic [GRID_W-1:0]  grid_w;
      logic [MERGE_W-1:0] merge;
      logic [SIDE_W-1:0]  side;
   } stage_a_type;

   typedef struct packed {
      logic               err;
      logic [GRID_W-1:0]  grid_h;
      logic [GRID_W-1:0]  grid_w;
      logic [MERGE_W-1:0] merge;
      logic [MW_W-1:0]    mw;
      logic [MM_W-1:0]    mm;
      logic [SIDE_W-1:0]  side;
   } stage_b_type;

   typedef struct packed {
      logic               err;
      logic [GRID_W-1:0]  grid_h;
      logic [GRID_W-1:0]  grid_w;
      logic [MERGE_W-1:0] merge;
      logic [MM_W-1:0]    mm;
      logic [SIDE_W-1:0]  side;
   } stage_c_type;

   typedef struct packed {
      logic               err;
      logic [GRID_W-1:0]  grid_h;
      logic [GRID_W-1:0]  grid_w;
      logic [MERGE_W-1:0] merge;
      logic [SIDE_W-1:0]  side;
      logic [POS_W-1:0]   grp_row;
   } stage_d_type;

   typedef struct packed {
      logic               err;
      logic [GRID_W-1:0]  grid_h;
      logic [GRID_W-1:0]  grid_w;
      logic [MERGE_W-1:0] merge;
      logic [SIDE_W-1:0]  side;
      logic [POS_W-1:0]   grp_row;
      logic [POS_W-1:0]   grp_col;
   } stage_e_type;

endpackage

/* hdl/pebt_div.sv */
// pebt_div: pipelined restoring divider, one quotient bit per stage,
// with a sideband word that travels alongside; no dependencies
module pebt_div #(
   parameter int NW = 8,
   parameter int DW = 4,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [NW-1:0] quotient,
   output logic [DW-1:0] remainder,
   output logic [SW-1:0] side_out
);

   logic          vld_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] div_ff [NW];
   logic [SW-1:0] sb_ff  [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic          vld_prev;
      logic [NW-1:0] quo_prev;
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] div_prev;
      logic [SW-1:0] sb_prev;
      logic [DW:0]   shifted;
      logic [DW:0]   diff;
      logic          fits;

      if (i == 0) begin : g_first
         assign vld_prev = in_valid;
         assign quo_prev = dividend;
         assign rem_prev = '0;
         assign div_prev = divisor;
         assign sb_prev  = side_in;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign div_prev = div_ff[i-1];
         assign sb_prev  = sb_ff[i-1];
      end

      assign shifted = {rem_prev, quo_prev[NW-1]};
      assign diff    = shifted - {1'b0, div_prev};
      assign fits    = shifted >= {1'b0, div_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
         rem_ff[i] <= fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_ff[i] <= {quo_prev[NW-2:0], fits};
         div_ff[i] <= div_prev;
         sb_ff[i]  <= sb_prev;
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign quotient  = quo_ff[NW-1];
   assign remainder = rem_ff[NW-1];
   assign side_out  = sb_ff[NW-1];

endmodule

/* hdl/pos_embed_bilinear_taps_core.sv */
// pos_embed_bilinear_taps_core: top level of the bilinear tap generator
// depends on pebt_pkg and pebt_div
//
// usage:
//   an item is taken at a rising edge with start high and busy low; busy
//   stays low, so one item may be issued in every cycle
//   each item carries a flat patch index and its grid height and width
//   exactly one result per item appears on the rsp_ ports for one cycle,
//   marked by rsp_valid, in the order in which the items were taken
//   throughput is one item per cycle; items pass through a chain of pipelined
//   dividers, one quotient bit per stage (grid check, index modulo, block
//   decode, and the align-corners quotient with its Q0.16 fraction)
//   the receiver cannot stall; results are never held back
//   csr_ writes set table_side (index 0) and the merge block side (index 1),
//   each taken at the edge where csr_write_enable is high; write only when
//   no item is in flight
//   synchronous reset restores table_side 48 and merge side 2 and drops
//   every item in flight; no clearing pass is needed
module pos_embed_bilinear_taps_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pebt_pkg::INDEX_W-1:0]         req_patch_index,
   input  logic [pebt_pkg::GRID_W-1:0]          req_grid_h,
   input  logic [pebt_pkg::GRID_W-1:0]          req_grid_w,
   input  logic                                 csr_write_enable,
   input  logic [pebt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pebt_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   output logic [pebt_pkg::TAP_W-1:0]           rsp_tap_top_left,
   output logic [pebt_pkg::TAP_W-1:0]           rsp_tap_top_right,
   output logic [pebt_pkg::TAP_W-1:0]           rsp_tap_bottom_left,
   output logic [pebt_pkg::TAP_W-1:0]           rsp_tap_bottom_right,
   output logic [pebt_pkg::WEIGHT_W-1:0]        rsp_weight_top_left,
   output logic [pebt_pkg::WEIGHT_W-1:0]        rsp_weight_top_right,
   output logic [pebt_pkg::WEIGHT_W-1:0]        rsp_weight_bottom_left,
   output logic [pebt_pkg::WEIGHT_W-1:0]        rsp_weight_bottom_right,
   output logic                                 rsp_grid_error
);

   import pebt_pkg::*;

   // configuration
   logic [SIDE_W-1:0]  table_side_ff;
   logic [MERGE_W-1:0] merge_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_side_ff <= TABLE_SIDE_RESET;
         merge_dim_ff  <= MERGE_DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TABLE_SIDE: table_side_ff <= csr_data;
            CSR_MERGE_DIM:  merge_dim_ff  <= csr_data[MERGE_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage a: capture item and effective config
   logic               accept;
   logic [MERGE_W-1:0] merge_eff;
   logic [SIDE_W-1:0]  side_eff;
   logic               range_bad;
   logic               a_valid_ff;
   stage_a_type        a_data_ff;
   logic               a_range_bad_ff;

   assign accept    = start & ~busy;
   assign merge_eff = (merge_dim_ff == '0) ? MERGE_W'(1) : merge_dim_ff;
   always_comb begin
      priority if (table_side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (table_side_ff > SIDE_W'(MAX_TABLE_SIDE)) begin
         side_eff = SIDE_W'(MAX_TABLE_SIDE);
      end else begin
         side_eff = table_side_ff;
      end
   end
   assign range_bad = (req_grid_h == '0) || (req_grid_w == '0) ||
                      (req_grid_h > GRID_W'(MAX_GRID_DIM)) ||
                      (req_grid_w > GRID_W'(MAX_GRID_DIM));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_data_ff.patch  <= req_patch_index;
      a_data_ff.grid_h <= req_grid_h;
      a_data_ff.grid_w <= req_grid_w;
      a_data_ff.merge  <= merge_eff;
      a_data_ff.side   <= side_eff;
      a_range_bad_ff   <= range_bad;
   end

   // grid divisibility by merge
   logic               dh_valid, dw_valid;
   logic [MERGE_W-1:0] h_rem, w_rem;
   stage_a_type        dh_data;
   logic               dw_range_bad;

   pebt_div #(.NW(GRID_W), .DW(MERGE_W), .SW($bits(stage_a_type))) u_div_h (
      .clock, .reset,
      .in_valid(a_valid_ff), .dividend(a_data_ff.grid_h), .divisor(a_data_ff.merge),
      .side_in(a_data_ff), .out_valid(dh_valid), .quotient(), .remainder(h_rem),
      .side_out(dh_data)
   );

   pebt_div #(.NW(GRID_W), .DW(MERGE_W), .SW(1)) u_div_w (
      .clock, .reset,
      .in_valid(a_valid_ff), .dividend(a_data_ff.grid_w), .divisor(a_data_ff.merge),
      .side_in(a_range_bad_ff), .out_valid(dw_valid), .quotient(), .remainder(w_rem),
      .side_out(dw_range_bad)
   );

   // stage b: error flag and products for decoding
   logic               b_valid_ff;
   logic [INDEX_W-1:0] b_patch_ff;
   logic [HW_W-1:0]    b_hw_ff;
   stage_b_type        b_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= dh_valid & dw_valid;
      end
      b_patch_ff       <= dh_data.patch;
      b_hw_ff          <= HW_W'(dh_data.grid_h * dh_data.grid_w);
      b_data_ff.err    <= dw_range_bad || (h_rem != '0) || (w_rem != '0);
      b_data_ff.grid_h <= dh_data.grid_h;
      b_data_ff.grid_w <= dh_data.grid_w;
      b_data_ff.merge  <= dh_data.merge;
      b_data_ff.mw     <= MW_W'(dh_data.merge * dh_data.grid_w);
      b_data_ff.mm     <= MM_W'(dh_data.merge * dh_data.merge);
      b_data_ff.side   <= dh_data.side;
   end

   // index modulo frame size
   logic            d1_valid;
   logic [HW_W-1:0] frame_pos;
   stage_b_type     d1_data;

   pebt_div #(.NW(INDEX_W), .DW(HW_W), .SW($bits(stage_b_type))) u_div_frame (
      .clock, .reset,
      .in_valid(b_valid_ff), .dividend(b_patch_ff), .divisor(b_hw_ff),
      .side_in(b_data_ff), .out_valid(d1_valid), .quotient(), .remainder(frame_pos),
      .side_out(d1_data)
   );

   // block row
   stage_c_type     d2_in;
   logic            d2_valid;
   logic [HW_W-1:0] d2_quo;
   logic [MW_W-1:0] in_row;
   stage_c_type     d2_data;

   assign d2_in = '{err: d1_data.err, grid_h: d1_data.grid_h, grid_w: d1_data.grid_w,
                    merge: d1_data.merge, mm: d1_data.mm, side: d1_data.side};

   pebt_div #(.NW(HW_W), .DW(MW_W), .SW($bits(stage_c_type))) u_div_row (
      .clock, .reset,
      .in_valid(d1_valid), .dividend(frame_pos), .divisor(d1_data.mw),
      .side_in(d2_in), .out_valid(d2_valid), .quotient(d2_quo), .remainder(in_row),
      .side_out(d2_data)
   );

   // block column
   stage_d_type     d3_in;
   logic            d3_valid;
   logic [MW_W-1:0] d3_quo;
   logic [MM_W-1:0] inner;
   stage_d_type     d3_data;

   assign d3_in = '{err: d2_data.err, grid_h: d2_data.grid_h, grid_w: d2_data.grid_w,
                    merge: d2_data.merge, side: d2_data.side,
                    grp_row: d2_quo[POS_W-1:0]};

   pebt_div #(.NW(MW_W), .DW(MM_W), .SW($bits(stage_d_type))) u_div_col (
      .clock, .reset,
      .in_valid(d2_valid), .dividend(in_row), .divisor(d2_data.mm),
      .side_in(d3_in), .out_valid(d3_valid), .quotient(d3_quo), .remainder(inner),
      .side_out(d3_data)
   );

   // position inside the block
   stage_e_type        d4_in;
   logic               d4_valid;
   logic [MM_W-1:0]    d4_quo;
   logic [MERGE_W-1:0] inner_col;
   stage_e_type        d4_data;

   assign d4_in = '{err: d3_data.err, grid_h: d3_data.grid_h, grid_w: d3_data.grid_w,
                    merge: d3_data.merge, side: d3_data.side,
                    grp_row: d3_data.grp_row, grp_col: d3_quo[POS_W-1:0]};

   pebt_div #(.NW(MM_W), .DW(MERGE_W), .SW($bits(stage_e_type))) u_div_inner (
      .clock, .reset,
      .in_valid(d3_valid), .dividend(inner), .divisor(d3_data.merge),
      .side_in(d4_in), .out_valid(d4_valid), .quotient(d4_quo), .remainder(inner_col),
      .side_out(d4_data)
   );

   // stage c: row, column and divisors
   logic              c_valid_ff;
   logic              c_err_ff;
   logic [POS_W-1:0]  c_row_ff, c_col_ff;
   logic [DEN_W-1:0]  c_den_r_ff, c_den_c_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic [GRID_W-1:0] h_m1, w_m1;

   assign h_m1 = d4_data.grid_h - GRID_W'(1);
   assign w_m1 = d4_data.grid_w - GRID_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d4_valid;
      end
      c_err_ff   <= d4_data.err;
      c_row_ff   <= POS_W'(d4_data.grp_row * d4_data.merge) +
                    POS_W'(d4_quo[INNER_POS_W-1:0]);
      c_col_ff   <= POS_W'(d4_data.grp_col * d4_data.merge) + POS_W'(inner_col);
      c_den_r_ff <= (d4_data.grid_h > GRID_W'(1)) ? h_m1[DEN_W-1:0] : DEN_W'(1);
      c_den_c_ff <= (d4_data.grid_w > GRID_W'(1)) ? w_m1[DEN_W-1:0] : DEN_W'(1);
      c_side_ff  <= d4_data.side;
   end

   // stage d: scaled numerators with half-divisor rounding
   logic                  d_valid_ff;
   logic                  d_err_ff;
   logic [DIVIDEND_W-1:0] d_num_r_ff, d_num_c_ff;
   logic [DEN_W-1:0]      d_den_r_ff, d_den_c_ff;
   logic [SIDE_W-1:0]     d_side_ff;
   logic [SIDE_W-1:0]     c_side_m1;
   logic [NUM_W-1:0]      num_r, num_c;

   assign c_side_m1 = c_side_ff - SIDE_W'(1);
   assign num_r     = NUM_W'(c_row_ff * c_side_m1[STEP_W-1:0]);
   assign num_c     = NUM_W'(c_col_ff * c_side_m1[STEP_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_err_ff   <= c_err_ff;
      d_num_r_ff <= {num_r, FRAC_BITS'(c_den_r_ff >> 1)};
      d_num_c_ff <= {num_c, FRAC_BITS'(c_den_c_ff >> 1)};
      d_den_r_ff <= c_den_r_ff;
      d_den_c_ff <= c_den_c_ff;
      d_side_ff  <= c_side_ff;
   end

   // align-corners quotients: integer tap above the fraction bits
   logic                  dr_valid, dc_valid;
   logic [DIVIDEND_W-1:0] q_r, q_c;
   logic [SIDE_W-1:0]     dr_side;
   logic                  dc_err;

   pebt_div #(.NW(DIVIDEND_W), .DW(DEN_W), .SW(SIDE_W)) u_div_src_r (
      .clock, .reset,
      .in_valid(d_valid_ff), .dividend(d_num_r_ff), .divisor(d_den_r_ff),
      .side_in(d_side_ff), .out_valid(dr_valid), .quotient(q_r), .remainder(),
      .side_out(dr_side)
   );

   pebt_div #(.NW(DIVIDEND_W), .DW(DEN_W), .SW(1)) u_div_src_c (
      .clock, .reset,
      .in_valid(d_valid_ff), .dividend(d_num_c_ff), .divisor(d_den_c_ff),
      .side_in(d_err_ff), .out_valid(dc_valid), .quotient(q_c), .remainder(),
      .side_out(dc_err)
   );

   // stage e: clamped taps and axis weights
   logic [SIDE_W-1:0]   top_tap;
   logic [NUM_W-1:0]    base_r, base_c;
   logic [NUM_W:0]      next_r, next_c;
   logic [FRAC_BITS-1:0] hi_r, hi_c;
   logic                e_valid_ff;
   logic                e_err_ff;
   logic [SIDE_W-1:0]   e_side_ff;
   logic [STEP_W-1:0]   e_tr_ff [2];
   logic [STEP_W-1:0]   e_tc_ff [2];
   logic [WEIGHT_W-1:0] e_wr_ff [2];
   logic [WEIGHT_W-1:0] e_wc_ff [2];

   assign top_tap = dr_side - SIDE_W'(1);
   assign base_r  = q_r[DIVIDEND_W-1:FRAC_BITS];
   assign base_c  = q_c[DIVIDEND_W-1:FRAC_BITS];
   assign next_r  = {1'b0, base_r} + (NUM_W+1)'(1);
   assign next_c  = {1'b0, base_c} + (NUM_W+1)'(1);
   assign hi_r    = q_r[FRAC_BITS-1:0];
   assign hi_c    = q_c[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= dr_valid & dc_valid;
      end
      e_err_ff   <= dc_err;
      e_side_ff  <= dr_side;
      e_tr_ff[0] <= (base_r > NUM_W'(top_tap)) ? top_tap[STEP_W-1:0] : base_r[STEP_W-1:0];
      e_tr_ff[1] <= (next_r > (NUM_W+1)'(top_tap)) ? top_tap[STEP_W-1:0]
                                                   : next_r[STEP_W-1:0];
      e_tc_ff[0] <= (base_c > NUM_W'(top_tap)) ? top_tap[STEP_W-1:0] : base_c[STEP_W-1:0];
      e_tc_ff[1] <= (next_c > (NUM_W+1)'(top_tap)) ? top_tap[STEP_W-1:0]
                                                   : next_c[STEP_W-1:0];
      e_wr_ff[0] <= WEIGHT_ONE - WEIGHT_W'(hi_r);
      e_wr_ff[1] <= WEIGHT_W'(hi_r);
      e_wc_ff[0] <= WEIGHT_ONE - WEIGHT_W'(hi_c);
      e_wc_ff[1] <= WEIGHT_W'(hi_c);
   end

   // stage f: flat table indices and weight products
   logic              f_valid_ff;
   logic              f_err_ff;
   logic [TAP_W-1:0]  f_tap_ff  [4];
   logic [PROD_W-1:0] f_prod_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_err_ff <= e_err_ff;
      for (int a = 0; a < 2; a++) begin
         for (int b = 0; b < 2; b++) begin
            f_tap_ff[a*2+b]  <= TAP_W'(e_tr_ff[a] * e_side_ff) + TAP_W'(e_tc_ff[b]);
            f_prod_ff[a*2+b] <= PROD_W'(e_wr_ff[a] * e_wc_ff[b]);
         end
      end
   end

   // stage g: rounding, error masking, output register
   logic                rsp_valid_ff;
   logic                rsp_err_ff;
   logic [TAP_W-1:0]    rsp_tap_ff    [4];
   logic [WEIGHT_W-1:0] rsp_weight_ff [4];
   logic [PROD_W-1:0]   rounded       [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rounded[k] = (f_prod_ff[k] + PROD_HALF) >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid_ff;
      end
      rsp_err_ff <= f_err_ff;
      for (int k = 0; k < 4; k++) begin
         rsp_tap_ff[k]    <= f_err_ff ? '0 : f_tap_ff[k];
         rsp_weight_ff[k] <= f_err_ff ? '0 : rounded[k][WEIGHT_W-1:0];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_grid_error          = rsp_err_ff;
   assign rsp_tap_top_left        = rsp_tap_ff[0];
   assign rsp_tap_top_right       = rsp_tap_ff[1];
   assign rsp_tap_bottom_left     = rsp_tap_ff[2];
   assign rsp_tap_bottom_right    = rsp_tap_ff[3];
   assign rsp_weight_top_left     = rsp_weight_ff[0];
   assign rsp_weight_top_right    = rsp_weight_ff[1];
   assign rsp_weight_bottom_left  = rsp_weight_ff[2];
   assign rsp_weight_bottom_right = rsp_weight_ff[3];

endmodule

/* hdl/pebt_checker.sv */
// pebt_checker: port-level checks on the bilinear tap generator
// depends on pebt_pkg; bound to pos_embed_bilinear_taps_core
module pebt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [pebt_pkg::TAP_W-1:0]       rsp_tap_top_left,
   input logic [pebt_pkg::TAP_W-1:0]       rsp_tap_top_right,
   input logic [pebt_pkg::TAP_W-1:0]       rsp_tap_bottom_left,
   input logic [pebt_pkg::TAP_W-1:0]       rsp_tap_bottom_right,
   input logic [pebt_pkg::WEIGHT_W-1:0]    rsp_weight_top_left,
   input logic [pebt_pkg::WEIGHT_W-1:0]    rsp_weight_top_right,
   input logic [pebt_pkg::WEIGHT_W-1:0]    rsp_weight_bottom_left,
   input logic [pebt_pkg::WEIGHT_W-1:0]    rsp_weight_bottom_right,
   input logic                             rsp_grid_error
);

   import pebt_pkg::*;

   logic [WEIGHT_W+1:0] weight_sum;

   assign weight_sum = (WEIGHT_W+2)'(rsp_weight_top_left) +
                       (WEIGHT_W+2)'(rsp_weight_top_right) +
                       (WEIGHT_W+2)'(rsp_weight_bottom_left) +
                       (WEIGHT_W+2)'(rsp_weight_bottom_right);

   // every item taken yields its result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("item taken without a result after the pipeline latency");

   // no result without an item taken that far back
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result with no matching item");

   // rejected grid gives all-zero taps and weights
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_grid_error) |->
         (rsp_tap_top_left == '0 && rsp_tap_top_right == '0 &&
          rsp_tap_bottom_left == '0 && rsp_tap_bottom_right == '0 &&
          weight_sum == '0))
      else $error("rejected grid with nonzero fields");

   // four rounded weights add up to one within rounding
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_grid_error) |->
         (weight_sum >= (WEIGHT_W+2)'(WEIGHT_ONE) - (WEIGHT_W+2)'(2) &&
          weight_sum <= (WEIGHT_W+2)'(WEIGHT_ONE) + (WEIGHT_W+2)'(2)))
      else $error("weights do not sum to one");

endmodule

bind pos_embed_bilinear_taps_core pebt_checker u_pebt_checker (.*);
